>>> hdl/mse_pkg.sv
// shared types for the merge sort engine
`default_nettype none

package mse_pkg;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,   // taking elements into bank 0
    ST_PASS,   // start of a merge pass, or done sorting
    ST_SEG,    // set up the two runs of one merge segment
    ST_MERGE,  // one element merged per cycle
    ST_OUT     // streaming the sorted set out
  } mse_state_e;

endpackage

`default_nettype wire

>>> hdl/mse_ram.sv
// simple dual-read-port ram with registered read data
`default_nettype none

module mse_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

>>> hdl/merge_sort_engine_unit.sv
// top level of the stable merge sort engine
`default_nettype none

// Stable merge sort engine. Signed values stream in one transaction per cycle
// and are stored until a transaction with tlast arrives; at most MAX_ELEMENTS
// are kept, later ones are dropped and reported on tuser of every result of
// that set. The set is then sorted in ascending order (ties keep load order)
// by bottom-up merge passes between two ram banks, ping-ponging so no copy
// pass is needed. A single compare-and-select unit merges one element per
// cycle, bounded by the single write port of the destination bank; each
// segment also has a setup state and each pass a pass state of its own. The
// sorted set then leaves at one transaction per cycle while m_axis_tready is
// high, tlast on the final one. Input tready is low from the tlast
// transaction until the last result has been taken.

module merge_sort_engine_unit #(
  parameter int MAX_ELEMENTS = 64,
  parameter int DATA_WIDTH   = 32,
  localparam int TDATA_WIDTH = ((DATA_WIDTH + 7) / 8) * 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input stream
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [TDATA_WIDTH-1:0] s_axis_tdata_i,   // item_value
  input  wire logic                   s_axis_tlast_i,   // last_item
  // result stream
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic      [TDATA_WIDTH-1:0] m_axis_tdata_o,   // sorted_value
  output logic                        m_axis_tlast_o,   // final_result
  output logic                        m_axis_tuser_o    // overflow_flag
);

  import mse_pkg::*;

  localparam int AddrW = $clog2(MAX_ELEMENTS);
  localparam int CntW  = $clog2(MAX_ELEMENTS + 1);
  // positions and run bounds can reach about three times the set size
  localparam int PosW  = CntW + 2;
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_ELEMENTS);

  mse_state_e state_q, state_d;

  logic [CntW-1:0] cnt_q, cnt_d;        // elements held in the current set
  logic            drop_q, drop_d;      // some element of this set was dropped
  logic            src_q, src_d;        // bank that holds the current runs
  logic [PosW-1:0] width_q, width_d;    // run length of this pass
  logic [PosW-1:0] lo_q, lo_d;
  logic [PosW-1:0] mid_q, mid_d;
  logic [PosW-1:0] hi_q, hi_d;
  logic [PosW-1:0] a_q, a_d;            // left run read position
  logic [PosW-1:0] b_q, b_d;            // right run read position
  logic [PosW-1:0] w_q, w_d;            // write position in destination bank
  logic [CntW-1:0] k_q, k_d;            // output position

  // bank ports
  logic                  we0, we1;
  logic [AddrW-1:0]      waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [AddrW-1:0]      raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
  logic [DATA_WIDTH-1:0] head_a, head_b;

  // shared compare-and-select unit and loop bounds
  logic [PosW-1:0] n_ext;
  logic [PosW-1:0] two_width;
  logic [PosW-1:0] lo_next;
  logic [PosW-1:0] mid_raw, hi_raw;
  logic            take_left;
  logic            seg_end;
  logic            pass_end;
  logic            sort_done;
  logic            in_fire, out_fire;
  logic            out_end;

  assign n_ext     = PosW'(cnt_q);
  assign two_width = {width_q[PosW-2:0], 1'b0};
  assign lo_next   = lo_q + two_width;
  assign mid_raw   = lo_q + width_q;
  assign hi_raw    = lo_q + two_width;
  assign head_a    = src_q ? rd1_a : rd0_a;
  assign head_b    = src_q ? rd1_b : rd0_b;
  // left wins ties so equal values keep load order
  assign take_left = (a_q < mid_q) &&
                     ((b_q >= hi_q) || ($signed(head_a) <= $signed(head_b)));
  assign seg_end   = (w_q + PosW'(1)) == hi_q;
  assign pass_end  = lo_next >= n_ext;
  assign sort_done = width_q >= n_ext;
  assign in_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire  = m_axis_tvalid_o && m_axis_tready_i;
  assign out_end   = (k_q + CntW'(1)) == cnt_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_fire && s_axis_tlast_i) state_d = ST_PASS;
      end
      ST_PASS: begin
        state_d = sort_done ? ST_OUT : ST_SEG;
      end
      ST_SEG: begin
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        if (seg_end) state_d = pass_end ? ST_PASS : ST_SEG;
      end
      ST_OUT: begin
        if (out_fire && out_end) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // datapath control and outputs
  always_comb begin
    cnt_d   = cnt_q;
    drop_d  = drop_q;
    src_d   = src_q;
    width_d = width_q;
    lo_d    = lo_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    a_d     = a_q;
    b_d     = b_q;
    w_d     = w_q;
    k_d     = k_q;
    we0     = 1'b0;
    we1     = 1'b0;
    waddr   = cnt_q[AddrW-1:0];
    wdata   = s_axis_tdata_i[DATA_WIDTH-1:0];
    s_axis_tready_o = 1'b0;
    m_axis_tvalid_o = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        src_d   = 1'b0;
        width_d = PosW'(1);
        lo_d    = '0;
        if (in_fire) begin
          if (cnt_q < MaxCnt) begin
            we0   = 1'b1;
            cnt_d = cnt_q + CntW'(1);
          end else begin
            drop_d = 1'b1;
          end
        end
      end
      ST_PASS: begin
        lo_d = '0;
        k_d  = '0;
      end
      ST_SEG: begin
        // runs are clipped at the end of the set
        mid_d = (mid_raw > n_ext) ? n_ext : mid_raw;
        hi_d  = (hi_raw > n_ext) ? n_ext : hi_raw;
        a_d   = lo_q;
        b_d   = mid_d;
        w_d   = lo_q;
      end
      ST_MERGE: begin
        waddr = w_q[AddrW-1:0];
        wdata = take_left ? head_a : head_b;
        we0   = src_q;
        we1   = !src_q;
        w_d   = w_q + PosW'(1);
        if (take_left) begin
          a_d = a_q + PosW'(1);
        end else begin
          b_d = b_q + PosW'(1);
        end
        if (seg_end) begin
          if (pass_end) begin
            width_d = two_width;
            src_d   = !src_q;
          end else begin
            lo_d = lo_next;
          end
        end
      end
      ST_OUT: begin
        m_axis_tvalid_o = 1'b1;
        if (out_fire) begin
          k_d = k_q + CntW'(1);
          if (out_end) begin
            cnt_d  = '0;
            drop_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // read addresses follow the next positions so the registered read data lines up with the current positions
  assign raddr_a = (state_q == ST_OUT || state_q == ST_PASS) ? k_d[AddrW-1:0]
                                                             : a_d[AddrW-1:0];
  assign raddr_b = b_d[AddrW-1:0];

  assign m_axis_tdata_o = TDATA_WIDTH'(head_a);
  assign m_axis_tlast_o = out_end;
  assign m_axis_tuser_o = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      drop_q  <= 1'b0;
      src_q   <= 1'b0;
      width_q <= '0;
      lo_q    <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      a_q     <= '0;
      b_q     <= '0;
      w_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      drop_q  <= drop_d;
      src_q   <= src_d;
      width_q <= width_d;
      lo_q    <= lo_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      a_q     <= a_d;
      b_q     <= b_d;
      w_q     <= w_d;
      k_q     <= k_d;
    end
  end

  // bank 0 takes the load; merge passes alternate between the banks
  mse_ram #(
    .DEPTH(MAX_ELEMENTS),
    .WIDTH(DATA_WIDTH),
    .AW   (AddrW)
  ) u_bank0 (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd0_a),
    .rdata_b_o(rd0_b)
  );

  mse_ram #(
    .DEPTH(MAX_ELEMENTS),
    .WIDTH(DATA_WIDTH),
    .AW   (AddrW)
  ) u_bank1 (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_a_i(raddr_a),
    .raddr_b_i(raddr_b),
    .rdata_a_o(rd1_a),
    .rdata_b_o(rd1_b)
  );

endmodule

`default_nettype wire
